[rtl/core/thermocycle_pid_controller_macros.svh]
// Assertion helpers used by the file that checks the controller.
`ifndef THERMOCYCLE_PID_CONTROLLER_MACROS_SVH
`define THERMOCYCLE_PID_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tpc_pkg.sv]
package tpc_pkg;

  localparam int ADC_BITS_DEF = 24;

  localparam int RAW_W   = 24;
  localparam int CFG_W   = 20;
  localparam int ADDR_W  = 3;
  localparam int GAINT_W = 20;
  localparam int CJ_W    = 17;
  localparam int THR_W   = 16;
  localparam int CYC_W   = 6;
  localparam int GAIN_W  = 16;
  localparam int TEMP_W  = 20;
  localparam int CNT_W   = 7;
  localparam int DRIVE_W = 8;

  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int WIDE_W  = 22;
  localparam int VAL_W   = 21;
  localparam int ACC_W   = 40;
  localparam int FRAC_W  = 8;
  localparam int INTEG_W = 16;
  localparam int DRIVE_SH = 16;

  localparam logic [GAINT_W-1:0] TC_GAIN_RST = 20'd522486;
  localparam logic [CJ_W-1:0]    CJ_RST      = 17'd6400;
  localparam logic [THR_W-1:0]   UPPER_RST   = 16'd24320;
  localparam logic [THR_W-1:0]   LOWER_RST   = 16'd15360;
  localparam logic [CYC_W-1:0]   CYCLE_RST   = 6'd30;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST  = 16'd1280;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST  = 16'd256;

  typedef enum logic [ADDR_W-1:0] {
    REG_TC_GAIN = 3'd0,
    REG_CJ_TEMP = 3'd1,
    REG_UPPER   = 3'd2,
    REG_LOWER   = 3'd3,
    REG_CYCLES  = 3'd4,
    REG_GAIN_P  = 3'd5,
    REG_GAIN_I  = 3'd6,
    REG_GAIN_D  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [GAINT_W-1:0]     tc_gain;
    logic signed [CJ_W-1:0] cj_temp;
    logic [THR_W-1:0]       upper;
    logic [THR_W-1:0]       lower;
    logic [CYC_W-1:0]       cycles;
    logic [GAIN_W-1:0]      gain_p;
    logic [GAIN_W-1:0]      gain_i;
    logic [GAIN_W-1:0]      gain_d;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_TEMP  = 2'd0,
    MUL_INT   = 2'd1,
    MUL_PROP  = 2'd2,
    MUL_DERIV = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_temp;
    logic     upd_integ;
    logic     upd_acc;
    logic     load_out;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ERR   = 3'd1,
    ST_INT   = 3'd2,
    ST_PROP  = 3'd3,
    ST_DERIV = 3'd4,
    ST_FIN   = 3'd5
  } state_t;

endpackage

[rtl/core/tpc_cfg.sv]
module tpc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tpc_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [tpc_pkg::CFG_W-1:0]   cfg_wdata,
  output tpc_pkg::cfg_t               cfg
);
  import tpc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_TC_GAIN: cfg_nxt.tc_gain = cfg_wdata[GAINT_W-1:0];
        REG_CJ_TEMP: cfg_nxt.cj_temp = cfg_wdata[CJ_W-1:0];
        REG_UPPER:   cfg_nxt.upper   = cfg_wdata[THR_W-1:0];
        REG_LOWER:   cfg_nxt.lower   = cfg_wdata[THR_W-1:0];
        REG_CYCLES:  cfg_nxt.cycles  = cfg_wdata[CYC_W-1:0];
        REG_GAIN_P:  cfg_nxt.gain_p  = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:  cfg_nxt.gain_i  = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:  cfg_nxt.gain_d  = cfg_wdata[GAIN_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tc_gain <= TC_GAIN_RST;
      cfg_r.cj_temp <= CJ_RST;
      cfg_r.upper   <= UPPER_RST;
      cfg_r.lower   <= LOWER_RST;
      cfg_r.cycles  <= CYCLE_RST;
      cfg_r.gain_p  <= GAIN_P_RST;
      cfg_r.gain_i  <= GAIN_I_RST;
      cfg_r.gain_d  <= GAIN_D_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/tpc_ctrl.sv]
module tpc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output tpc_pkg::cmd_t cmd
);
  import tpc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = MUL_TEMP;
    in_stall      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_TEMP;
          state_nxt   = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.upd_temp = 1'b1;
        state_nxt    = ST_INT;
      end
      ST_INT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INT;
        state_nxt   = ST_PROP;
      end
      ST_PROP: begin
        cmd.upd_integ = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_PROP;
        state_nxt     = ST_DERIV;
      end
      ST_DERIV: begin
        cmd.upd_acc = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DERIV;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // Hold the finished item until the result register is free.
        if (!(out_valid_r && out_stall)) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/tpc_dp.sv]
module tpc_dp #(
  parameter int ADC_BITS = tpc_pkg::ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tpc_pkg::cmd_t                      cmd,
  input  tpc_pkg::cfg_t                      cfg,
  input  logic [tpc_pkg::RAW_W-1:0]          raw_code,
  output logic [tpc_pkg::DRIVE_W-1:0]        drive_level,
  output logic                               cooling_flag,
  output logic signed [tpc_pkg::TEMP_W-1:0]  measured_temp,
  output logic [tpc_pkg::CNT_W-1:0]          transition_total,
  output logic                               aiming_high
);
  import tpc_pkg::*;

  localparam logic signed [WIDE_W-1:0] TEMP_MAX_W = 22'sd524287;
  localparam logic signed [WIDE_W-1:0] TEMP_MIN_W = -22'sd524288;
  localparam logic signed [WIDE_W-1:0] ONE_DEG_W  = 22'sd256;
  localparam logic signed [ACC_W-1:0]  INTEG_MAX_A = 40'sd65280;

  // Shared multiplier.
  logic [ADC_BITS-1:0]          code_low, code_diff;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]     prod_r;

  logic signed [VAL_W-1:0]      err_r, din_r;
  logic signed [TEMP_W-1:0]     t_r, prev_r;
  logic [INTEG_W-1:0]           integ_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic                         tgt_r, cool_r;
  logic [CNT_W-1:0]             cnt_r;

  assign code_low  = raw_code[ADC_BITS-1:0];
  assign code_diff = {~code_low[ADC_BITS-1], code_low[ADC_BITS-2:0]};

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_TEMP: begin
        mul_a = {{(MUL_A_W-ADC_BITS){code_diff[ADC_BITS-1]}}, code_diff};
        mul_b = {{(MUL_B_W-GAINT_W){1'b0}}, cfg.tc_gain};
      end
      MUL_INT: begin
        mul_a = {{(MUL_A_W-VAL_W){err_r[VAL_W-1]}}, err_r};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_i};
      end
      MUL_PROP: begin
        mul_a = {{(MUL_A_W-VAL_W){err_r[VAL_W-1]}}, err_r};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_p};
      end
      MUL_DERIV: begin
        mul_a = {{(MUL_A_W-VAL_W){din_r[VAL_W-1]}}, din_r};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_d};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Temperature, setpoint update and loop error.
  logic signed [PROD_W-1:0] t_shift;
  logic signed [WIDE_W-1:0] t_wide, t_ext, up_lim, lo_lim;
  logic signed [TEMP_W-1:0] t_sat;
  logic [CNT_W:0]           cnt_inc;
  logic                     allow, sw_down, sw_up, tgt_nxt, cool_nxt;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [THR_W-1:0]         setpoint;
  logic signed [VAL_W-1:0]  err_nxt, din_nxt;

  assign t_shift = prod_r >>> ADC_BITS;
  assign t_wide  = t_shift[WIDE_W-1:0] + {{(WIDE_W-CJ_W){cfg.cj_temp[CJ_W-1]}}, cfg.cj_temp};

  always_comb begin
    priority if (t_wide > TEMP_MAX_W) begin
      t_sat = TEMP_MAX_W[TEMP_W-1:0];
    end else if (t_wide < TEMP_MIN_W) begin
      t_sat = TEMP_MIN_W[TEMP_W-1:0];
    end else begin
      t_sat = t_wide[TEMP_W-1:0];
    end
  end

  assign t_ext  = {{(WIDE_W-TEMP_W){t_sat[TEMP_W-1]}}, t_sat};
  assign up_lim = {{(WIDE_W-THR_W){1'b0}}, cfg.upper} - ONE_DEG_W;
  assign lo_lim = {{(WIDE_W-THR_W){1'b0}}, cfg.lower} + ONE_DEG_W;

  // Switching is allowed while count + 1 < 2 * cycles, which is never true for zero cycles.
  assign cnt_inc = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};
  assign allow   = cnt_inc < {1'b0, cfg.cycles, 1'b0};
  assign sw_down = allow && tgt_r && (t_ext >= up_lim);
  assign sw_up   = allow && !tgt_r && (t_ext <= lo_lim);

  always_comb begin
    tgt_nxt  = tgt_r;
    cool_nxt = cool_r;
    cnt_nxt  = cnt_r;
    if (sw_down) begin
      tgt_nxt  = 1'b0;
      cool_nxt = 1'b1;
      cnt_nxt  = cnt_inc[CNT_W-1:0];
    end else if (sw_up) begin
      tgt_nxt  = 1'b1;
      cool_nxt = 1'b0;
      cnt_nxt  = cnt_inc[CNT_W-1:0];
    end
  end

  assign setpoint = tgt_nxt ? cfg.upper : cfg.lower;
  assign err_nxt  = {{(VAL_W-THR_W){1'b0}}, setpoint} - {t_sat[TEMP_W-1], t_sat};
  assign din_nxt  = {t_sat[TEMP_W-1], t_sat} - {prev_r[TEMP_W-1], prev_r};

  // Integral with clamping, then the output sum.
  logic signed [PROD_W-1:0] i_shift;
  logic signed [ACC_W-1:0]  isum, acc_nxt, o_sum;
  logic [INTEG_W-1:0]       integ_nxt;
  logic [DRIVE_W-1:0]       drive_nxt;

  assign i_shift = prod_r >>> FRAC_W;
  assign isum    = {{(ACC_W-INTEG_W){1'b0}}, integ_r} + i_shift[ACC_W-1:0];

  always_comb begin
    priority if (isum < 0) begin
      integ_nxt = '0;
    end else if (isum > INTEG_MAX_A) begin
      integ_nxt = INTEG_MAX_A[INTEG_W-1:0];
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  assign acc_nxt = {{(ACC_W-INTEG_W-FRAC_W){1'b0}}, integ_r, {FRAC_W{1'b0}}}
                 + prod_r[ACC_W-1:0];
  assign o_sum   = acc_r - prod_r[ACC_W-1:0];

  always_comb begin
    priority if (o_sum[ACC_W-1]) begin
      drive_nxt = '0;
    end else if (|o_sum[ACC_W-2:DRIVE_SH+DRIVE_W]) begin
      drive_nxt = '1;
    end else begin
      drive_nxt = o_sum[DRIVE_SH+DRIVE_W-1:DRIVE_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
      tgt_r   <= 1'b1;
      cnt_r   <= '0;
      cool_r  <= 1'b0;
    end else begin
      if (cmd.upd_temp) begin
        prev_r <= t_sat;
        tgt_r  <= tgt_nxt;
        cnt_r  <= cnt_nxt;
        cool_r <= cool_nxt;
      end
      if (cmd.upd_integ) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_temp) begin
      t_r   <= t_sat;
      err_r <= err_nxt;
      din_r <= din_nxt;
    end
    if (cmd.upd_acc) begin
      acc_r <= acc_nxt;
    end
    if (cmd.load_out) begin
      drive_level      <= drive_nxt;
      cooling_flag     <= cool_r;
      measured_temp    <= t_r;
      transition_total <= cnt_r;
      aiming_high      <= tgt_r;
    end
  end

endmodule

[rtl/core/thermocycle_pid_controller.sv]
// Thermocycling heater controller: each transaction on the input channel carries one raw
// offset-binary thermocouple code and yields exactly one result transaction holding the
// heater drive (0..255), the saturated Q.8 temperature, the setpoint direction, the cooling
// flag and the transition count. Items are processed one at a time through a single shared
// 25 x 21 signed multiplier that is used four times per item (temperature scaling, integral,
// proportional and derivative terms), so a new item is accepted only after the previous one
// has loaded its result. A waiting result sits in its own output register, so the next item
// is taken in while it is still pending. Configuration registers are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them only while no item is in flight, since the
// block itself does not enforce this.
`include "thermocycle_pid_controller_macros.svh"

module thermocycle_pid_controller #(
  parameter int ADC_BITS = tpc_pkg::ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tpc_pkg::ADDR_W-1:0]         cfg_addr,
  input  logic [tpc_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tpc_pkg::RAW_W-1:0]          in_raw_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tpc_pkg::DRIVE_W-1:0]        out_drive_level,
  output logic                               out_cooling_flag,
  output logic signed [tpc_pkg::TEMP_W-1:0]  out_measured_temp,
  output logic [tpc_pkg::CNT_W-1:0]          out_transition_total,
  output logic                               out_aiming_high
);
  import tpc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  tpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tpc_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .raw_code         (in_raw_code),
    .drive_level      (out_drive_level),
    .cooling_flag     (out_cooling_flag),
    .measured_temp    (out_measured_temp),
    .transition_total (out_transition_total),
    .aiming_high      (out_aiming_high)
  );

  `TPC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  `TPC_ASSERT_SAME(a_busy_through_sequence, in_valid && !in_stall, ##4 in_stall, "sequence cut short")
  `TPC_ASSERT_SAME(a_result_ends_busy, $rose(out_valid), $past(in_stall), "result without an item")

endmodule
